/* sv/bihg_pkg.sv */
// shared types, constants and crc helpers for the image header generator
// no dependencies
`default_nettype none

package bihg_pkg;

   // request kind codes
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_SWITCH  = 2'd1;
   localparam logic [1:0] KIND_FINISH  = 2'd2;

   localparam int unsigned HDR_LEN = 20;
   localparam int unsigned IDX_W   = $clog2(HDR_LEN);

   // header byte positions that the emitter treats specially
   localparam logic [IDX_W-1:0] POS_HCRC_LO = IDX_W'(14);
   localparam logic [IDX_W-1:0] POS_LAST    = IDX_W'(HDR_LEN - 1);

   localparam logic [7:0] MAGIC_0      = 8'h54;
   localparam logic [7:0] MAGIC_1      = 8'h45;
   localparam logic [7:0] MAGIC_2      = 8'h4E;
   localparam logic [7:0] VERSION_BYTE = 8'h01;
   localparam logic [7:0] FLAG_LE      = 8'h04;
   localparam logic [7:0] FLAG_DATA    = 8'h02;

   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // snapshot handed from the front end to the header emitter
   typedef struct packed {
      logic [15:0] code_len;
      logic [15:0] data_len;
      logic [31:0] crc32;
      logic        err;
   } snap_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // msb-first crc-16, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'd0};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* sv/bihg_hdr_emit.sv */
// header emitter: walks the 20 header bytes, or a single zero error beat, into the result register
// depends on bihg_pkg
`default_nettype none

module bihg_hdr_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire bihg_pkg::snap_type snap,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_last,
   output logic                   rsp_too_large
);

   logic                       active_ff;
   logic                       err_ff;
   logic [bihg_pkg::IDX_W-1:0] idx_ff;
   logic [15:0]                code_len_ff;
   logic [15:0]                data_len_ff;
   logic [31:0]                crc32_ff;
   logic [15:0]                crc16_ff;

   logic                       rsp_valid_ff;
   logic [7:0]                 out_byte_ff;
   logic                       is_last_ff;
   logic                       too_large_ff;

   logic                       load;
   logic                       last_beat;
   logic [7:0]                 hdr_byte;
   logic [7:0]                 flags;

   assign load      = active_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_beat = err_ff || (idx_ff == bihg_pkg::POS_LAST);
   assign flags     = bihg_pkg::FLAG_LE | ((data_len_ff != 16'd0) ? bihg_pkg::FLAG_DATA : 8'd0);

   always_comb begin
      case (idx_ff)
         5'd0:    hdr_byte = bihg_pkg::MAGIC_0;
         5'd1:    hdr_byte = bihg_pkg::MAGIC_1;
         5'd2:    hdr_byte = bihg_pkg::MAGIC_2;
         5'd3:    hdr_byte = bihg_pkg::VERSION_BYTE;
         5'd4:    hdr_byte = bihg_pkg::VERSION_BYTE;
         5'd5:    hdr_byte = flags;
         5'd6:    hdr_byte = code_len_ff[7:0];
         5'd7:    hdr_byte = code_len_ff[15:8];
         5'd8:    hdr_byte = code_len_ff[7:0];
         5'd9:    hdr_byte = code_len_ff[15:8];
         5'd10:   hdr_byte = data_len_ff[7:0];
         5'd11:   hdr_byte = data_len_ff[15:8];
         5'd14:   hdr_byte = crc16_ff[7:0];
         5'd15:   hdr_byte = crc16_ff[15:8];
         5'd16:   hdr_byte = crc32_ff[7:0];
         5'd17:   hdr_byte = crc32_ff[15:8];
         5'd18:   hdr_byte = crc32_ff[23:16];
         5'd19:   hdr_byte = crc32_ff[31:24];
         default: hdr_byte = 8'd0;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            active_ff <= 1'b1;
         end else if (load && last_beat) begin
            active_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff      <= '0;
         err_ff      <= snap.err;
         code_len_ff <= snap.code_len;
         data_len_ff <= snap.data_len;
         crc32_ff    <= snap.crc32;
         crc16_ff    <= bihg_pkg::CRC16_INIT;
      end else if (load) begin
         idx_ff <= idx_ff + 1'b1;
         // header crc covers the bytes ahead of its own field
         if (idx_ff < bihg_pkg::POS_HCRC_LO) begin
            crc16_ff <= bihg_pkg::crc16_byte(crc16_ff, hdr_byte);
         end
      end
      if (load) begin
         out_byte_ff  <= err_ff ? 8'd0 : hdr_byte;
         is_last_ff   <= last_beat;
         too_large_ff <= err_ff;
      end
   end

   assign busy          = active_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_is_last   = is_last_ff;
   assign rsp_too_large = too_large_ff;

endmodule

`default_nettype wire

/* sv/binary_image_header_generator_core.sv */
// image header generator top level: segment counters, payload crc-32, header emitter
// depends on bihg_pkg and bihg_hdr_emit
//
//   channel | direction | handshake            | beat contents
//   req_    | in        | req_valid, req_stall | req_kind, req_byte_value
//   rsp_    | out       | rsp_valid, rsp_stall | rsp_out_byte, rsp_is_last, rsp_too_large
//
// one request beat per cycle while req_stall is low; payload and switch beats drain from the input register at once
// a finish beat hands a snapshot to the emitter, which sends 20 header beats (or one error
// beat) at up to one per cycle while rsp_stall is low; payload beats keep flowing while the header goes out
// a finish beat waits in the input register while the emitter still runs the previous header
// reset (synchronous, active high) clears the input register, segment state and emitter
// rsp_stall holds the result register; req_stall rises only for a waiting finish beat
`default_nettype none

module binary_image_header_generator_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_byte_value,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_last,
   output logic            rsp_too_large
);

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_kind_ff;
   logic [7:0]  in_byte_ff;

   // segment state
   logic        data_mode_ff;
   logic [15:0] code_length_ff;
   logic [15:0] data_length_ff;
   logic        code_overflow_ff;
   logic        data_overflow_ff;
   logic [31:0] payload_crc_ff;

   logic               emit_busy;
   logic               in_take;
   logic               req_take;
   logic               finish_take;
   bihg_pkg::snap_type snap_in;

   // a finish beat must wait for the emitter, everything else drains at once
   assign in_take     = in_valid_ff && ((in_kind_ff != bihg_pkg::KIND_FINISH) || !emit_busy);
   assign req_stall   = in_valid_ff && !in_take;
   assign req_take    = req_valid && !req_stall;
   assign finish_take = in_take && (in_kind_ff == bihg_pkg::KIND_FINISH);

   always_comb begin
      snap_in.code_len = code_length_ff;
      snap_in.data_len = data_length_ff;
      snap_in.crc32    = payload_crc_ff ^ bihg_pkg::CRC32_INIT;
      snap_in.err      = code_overflow_ff || data_overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_byte_value;
      end
   end

   // segment counting and payload crc
   always_ff @(posedge clock) begin
      if (reset) begin
         data_mode_ff     <= 1'b0;
         code_length_ff   <= 16'd0;
         data_length_ff   <= 16'd0;
         code_overflow_ff <= 1'b0;
         data_overflow_ff <= 1'b0;
         payload_crc_ff   <= bihg_pkg::CRC32_INIT;
      end else if (in_take) begin
         case (in_kind_ff)
            bihg_pkg::KIND_PAYLOAD: begin
               payload_crc_ff <= bihg_pkg::crc32_byte(payload_crc_ff, in_byte_ff);
               if (data_mode_ff) begin
                  // count saturates, flag remembers the overrun
                  if (data_length_ff == bihg_pkg::LEN_MAX) begin
                     data_overflow_ff <= 1'b1;
                  end else begin
                     data_length_ff <= data_length_ff + 16'd1;
                  end
               end else begin
                  if (code_length_ff == bihg_pkg::LEN_MAX) begin
                     code_overflow_ff <= 1'b1;
                  end else begin
                     code_length_ff <= code_length_ff + 16'd1;
                  end
               end
            end
            bihg_pkg::KIND_SWITCH: begin
               data_mode_ff <= 1'b1;
            end
            bihg_pkg::KIND_FINISH: begin
               // snapshot already goes to the emitter, start fresh
               data_mode_ff     <= 1'b0;
               code_length_ff   <= 16'd0;
               data_length_ff   <= 16'd0;
               code_overflow_ff <= 1'b0;
               data_overflow_ff <= 1'b0;
               payload_crc_ff   <= bihg_pkg::CRC32_INIT;
            end
            default: begin
               // unused kind, dropped
            end
         endcase
      end
   end

   bihg_hdr_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .start         (finish_take),
      .snap          (snap_in),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_last   (rsp_is_last),
      .rsp_too_large (rsp_too_large)
   );

`ifndef SYNTHESIS
   // only a finish beat blocked by a running header may hold off the request side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_kind_ff == bihg_pkg::KIND_FINISH) && emit_busy)
      else $error("request stalled without a pending header run");

   // a taken finish starts the emitter and clears the segment state
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish_take |=> emit_busy && (code_length_ff == 16'd0) && (data_length_ff == 16'd0)
                      && !data_mode_ff && (payload_crc_ff == bihg_pkg::CRC32_INIT))
      else $error("finish did not start a header run with cleared state");

   // error beat is a single zero beat that closes the run
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_large) |-> rsp_is_last && (rsp_out_byte == 8'd0))
      else $error("malformed error beat");
`endif

endmodule

`default_nettype wire
